// ----- hw/rtl/rpd_pkg.sv -----
// Shared types, widths and constants of the PCX run-length plane decoder.
package rpd_pkg;

    // Field and register widths.
    localparam int DATA_W       = 8;
    localparam int ADDR_W       = 22;
    localparam int RUN_W        = 6;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 11;
    localparam int PLANES_REG_W = 3;
    localparam int LB_REG_W     = 12;

    // Configuration port.
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES   = 2'd3;

    // Run code marker and count mask.
    localparam logic [DATA_W-1:0] RUN_MARK = 8'hBF;
    localparam logic [DATA_W-1:0] RUN_MASK = 8'h3F;

    // Default parameter values.
    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 1024;
    localparam int DEF_MAX_PLANES     = 4;
    localparam int DEF_MAX_LINE_BYTES = 2048;

    // Controller states.
    typedef enum logic [0:0] {
        S_IDLE,
        S_EMIT
    } t_state;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  width;
        logic [HEIGHT_REG_W-1:0] height;
        logic [PLANES_REG_W-1:0] planes;
        logic [LB_REG_W-1:0]     line_bytes;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_run;
        logic put;
        logic out_free;
        logic item_end;
    } t_sts;

endpackage

// ----- hw/rtl/pcx_rle_plane_decoder_core.sv -----
// Top level of the PCX run-length plane decoder.
// An accepted byte is captured with its run state; the emit state then loads each result
// into the output register. The input is held off while a byte's repetitions are emitted;
// the emit sequencer steps one repetition per cycle while the output register has room.
// Reset (synchronous, active low) clears the run and position state, empties the output
// register and sets every configuration register to one.
module pcx_rle_plane_decoder_core #(
    parameter int MAX_WIDTH      = rpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = rpd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES     = rpd_pkg::DEF_MAX_PLANES,
    parameter int MAX_LINE_BYTES = rpd_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rpd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rpd_pkg::DATA_W-1:0]   i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rpd_pkg::ADDR_W-1:0]   o_pixel_address,
    output logic [rpd_pkg::DATA_W-1:0]   o_pixel_value,
    output logic                         o_last_of_run,
    output logic                         o_image_done
);

    rpd_pkg::t_cfg cfg;
    rpd_pkg::t_cmd cmd;
    rpd_pkg::t_sts sts;

    // Configuration registers.
    rpd_regs #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .MAX_PLANES     (MAX_PLANES),
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Controller.
    rpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath.
    rpd_dp #(
        .MAX_HEIGHT     (MAX_HEIGHT),
        .MAX_PLANES     (MAX_PLANES),
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last_of_run   (o_last_of_run),
        .o_image_done    (o_image_done)
    );

`ifndef SYNTHESIS
    // The result that completes the image is always the last one of its byte.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_done |-> o_last_of_run)
        else $error("image_done result without last_of_run");

    // Once the completing result is taken, nothing more comes out.
    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_image_done |=> !o_out_valid)
        else $error("result after image completion");

    // A new result only appears while the input side is held off.
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result loaded outside the emit sequence");
`endif

endmodule

// ----- hw/rtl/rpd_regs.sv -----
// Configuration register file with APB-style access and range clamping.
module rpd_regs #(
    parameter int MAX_WIDTH      = rpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = rpd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES     = rpd_pkg::DEF_MAX_PLANES,
    parameter int MAX_LINE_BYTES = rpd_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rpd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output rpd_pkg::t_cfg                o_cfg
);

    logic [rpd_pkg::WIDTH_REG_W-1:0]  r_width;
    logic [rpd_pkg::HEIGHT_REG_W-1:0] r_height;
    logic [rpd_pkg::PLANES_REG_W-1:0] r_planes;
    logic [rpd_pkg::LB_REG_W-1:0]     r_line_bytes;
    logic [rpd_pkg::CFG_IDX_W-1:0]    reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rpd_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; all registers come out of reset at one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= rpd_pkg::WIDTH_REG_W'(1);
            r_height     <= rpd_pkg::HEIGHT_REG_W'(1);
            r_planes     <= rpd_pkg::PLANES_REG_W'(1);
            r_line_bytes <= rpd_pkg::LB_REG_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                rpd_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= pwdata[rpd_pkg::WIDTH_REG_W-1:0];
                end
                rpd_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= pwdata[rpd_pkg::HEIGHT_REG_W-1:0];
                end
                rpd_pkg::REG_PLANE_COUNT: begin
                    r_planes <= pwdata[rpd_pkg::PLANES_REG_W-1:0];
                end
                rpd_pkg::REG_LINE_BYTES: begin
                    r_line_bytes <= pwdata[rpd_pkg::LB_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back the raw register values.
    always_comb begin
        case (reg_idx)
            rpd_pkg::REG_IMAGE_WIDTH:  prdata = rpd_pkg::PDATA_W'(r_width);
            rpd_pkg::REG_IMAGE_HEIGHT: prdata = rpd_pkg::PDATA_W'(r_height);
            rpd_pkg::REG_PLANE_COUNT:  prdata = rpd_pkg::PDATA_W'(r_planes);
            rpd_pkg::REG_LINE_BYTES:   prdata = rpd_pkg::PDATA_W'(r_line_bytes);
            default:                   prdata = '0;
        endcase
    end

    // Clamp each register to 1..MAX of its kind.
    always_comb begin
        if (r_width == '0) begin
            o_cfg.width = rpd_pkg::WIDTH_REG_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            o_cfg.width = rpd_pkg::WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end

        if (r_height == '0) begin
            o_cfg.height = rpd_pkg::HEIGHT_REG_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            o_cfg.height = rpd_pkg::HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_height;
        end

        if (r_planes == '0) begin
            o_cfg.planes = rpd_pkg::PLANES_REG_W'(1);
        end else if (int'(r_planes) > MAX_PLANES) begin
            o_cfg.planes = rpd_pkg::PLANES_REG_W'(MAX_PLANES);
        end else begin
            o_cfg.planes = r_planes;
        end

        if (r_line_bytes == '0) begin
            o_cfg.line_bytes = rpd_pkg::LB_REG_W'(1);
        end else if (int'(r_line_bytes) > MAX_LINE_BYTES) begin
            o_cfg.line_bytes = rpd_pkg::LB_REG_W'(MAX_LINE_BYTES);
        end else begin
            o_cfg.line_bytes = r_line_bytes;
        end
    end

endmodule

// ----- hw/rtl/rpd_ctrl.sv -----
// Controller state machine: takes bytes in and sequences the run repetitions.
module rpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rpd_pkg::t_sts i_sts,
    output rpd_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    rpd_pkg::t_state r_state;
    rpd_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a data byte (any byte that is not a run code) moves to the emit state, which
    // lasts until its final repetition has been taken.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpd_pkg::S_IDLE: begin
                if (i_in_valid && i_sts.start_run) begin
                    n_state = rpd_pkg::S_EMIT;
                end
            end
            rpd_pkg::S_EMIT: begin
                if ((i_sts.out_free || !i_sts.put) && i_sts.item_end) begin
                    n_state = rpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rpd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: a repetition steps when its result has room to go, or when it lies outside the image.
    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_in_stall   = 1'b1;
        case (r_state)
            rpd_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            rpd_pkg::S_EMIT: begin
                o_cmd.step = i_sts.out_free || !i_sts.put;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/rpd_dp.sv -----
// Datapath: run state, position counters, address arithmetic and output register.
module rpd_dp #(
    parameter int MAX_HEIGHT     = rpd_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PLANES     = rpd_pkg::DEF_MAX_PLANES,
    parameter int MAX_LINE_BYTES = rpd_pkg::DEF_MAX_LINE_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rpd_pkg::t_cfg               i_cfg,
    input  rpd_pkg::t_cmd               i_cmd,
    output rpd_pkg::t_sts               o_sts,
    input  logic [rpd_pkg::DATA_W-1:0]  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rpd_pkg::ADDR_W-1:0]  o_pixel_address,
    output logic [rpd_pkg::DATA_W-1:0]  o_pixel_value,
    output logic                        o_last_of_run,
    output logic                        o_image_done
);

    // Counter widths follow the largest bounds; column and row are capped by the register widths.
    localparam int COL_RAW = $clog2(MAX_LINE_BYTES);
    localparam int COL_W   = (COL_RAW < 1) ? 1 :
                             ((COL_RAW > rpd_pkg::LB_REG_W) ? rpd_pkg::LB_REG_W : COL_RAW);
    localparam int ROW_RAW = $clog2(MAX_HEIGHT);
    localparam int ROW_W   = (ROW_RAW < 1) ? 1 :
                             ((ROW_RAW > rpd_pkg::HEIGHT_REG_W) ? rpd_pkg::HEIGHT_REG_W : ROW_RAW);
    localparam int PL_RAW  = $clog2(MAX_PLANES);
    localparam int PL_W    = (PL_RAW < 1) ? 1 : PL_RAW;
    localparam int CMP_W   = rpd_pkg::LB_REG_W + 1;
    localparam int PCMP_W  = rpd_pkg::PLANES_REG_W + 1;
    localparam int RCMP_W  = rpd_pkg::HEIGHT_REG_W + 1;
    localparam int PROD_W  = ROW_W + rpd_pkg::WIDTH_REG_W;
    localparam int SCL_W   = rpd_pkg::ADDR_W + rpd_pkg::PLANES_REG_W;

    logic [rpd_pkg::RUN_W-1:0]  r_run;
    logic [rpd_pkg::RUN_W-1:0]  r_reps;
    logic [rpd_pkg::DATA_W-1:0] r_byte;
    logic [COL_W-1:0]           r_col;
    logic [PL_W-1:0]            r_plane;
    logic [ROW_W-1:0]           r_row;
    logic                       r_finished;
    logic [rpd_pkg::ADDR_W-1:0] r_base;

    logic                       r_out_valid;
    logic [rpd_pkg::ADDR_W-1:0] r_out_addr;
    logic [rpd_pkg::DATA_W-1:0] r_out_value;
    logic                       r_out_last;
    logic                       r_out_done;

    logic [PROD_W-1:0]          row_prod;
    logic [CMP_W-1:0]           col_ext;
    logic [CMP_W-1:0]           col_nx;
    logic [CMP_W-1:0]           width_ext;
    logic [PCMP_W-1:0]          plane_nx;
    logic [RCMP_W-1:0]          row_nx;
    logic                       put;
    logic                       line_end;
    logic                       plane_wrap;
    logic                       row_wrap;
    logic                       done;
    logic                       last;
    logic                       reps_one;
    logic [rpd_pkg::ADDR_W-1:0] pix_sum;
    logic [SCL_W-1:0]           pix_scaled;
    logic [rpd_pkg::ADDR_W-1:0] pix_addr;
    logic                       is_code;

    // Row base, registered every cycle; the row and width hold while a byte
    // is being written, so it is settled by the first repetition.
    assign row_prod = r_row * i_cfg.width;

    always_ff @(posedge i_clk) begin
        r_base <= rpd_pkg::ADDR_W'(row_prod);
    end

    // Position compares for the current repetition.
    assign col_ext    = CMP_W'(r_col);
    assign col_nx     = col_ext + CMP_W'(1);
    assign width_ext  = CMP_W'(i_cfg.width);
    assign put        = col_ext < width_ext;
    assign line_end   = col_nx >= CMP_W'(i_cfg.line_bytes);
    assign plane_nx   = PCMP_W'(r_plane) + PCMP_W'(1);
    assign plane_wrap = plane_nx >= PCMP_W'(i_cfg.planes);
    assign row_nx     = RCMP_W'(r_row) + RCMP_W'(1);
    assign row_wrap   = row_nx >= RCMP_W'(i_cfg.height);
    assign done       = (col_nx == width_ext) && plane_wrap && row_wrap;
    assign reps_one   = r_reps == rpd_pkg::RUN_W'(1);
    // Past the last image column the rest of the line is padding.
    assign last       = reps_one || line_end || (col_nx >= width_ext);

    // Interleaved address: (row*width + column)*planes + plane, kept to 22 bits.
    assign pix_sum    = r_base + rpd_pkg::ADDR_W'(r_col);
    assign pix_scaled = pix_sum * i_cfg.planes;
    assign pix_addr   = rpd_pkg::ADDR_W'(pix_scaled) + rpd_pkg::ADDR_W'(r_plane);

    // An input byte is a run code only when no run is pending.
    assign is_code = (r_run == '0) && (i_data_byte > rpd_pkg::RUN_MARK);

    assign o_sts.start_run = !r_finished && !is_code;
    assign o_sts.put       = put;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.item_end  = reps_one || line_end;

    // Run state and byte capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_reps <= '0;
        end else if (i_cmd.accept && !r_finished) begin
            if (is_code) begin
                r_run <= rpd_pkg::RUN_W'(i_data_byte & rpd_pkg::RUN_MASK);
            end else if (r_run == '0) begin
                r_reps <= rpd_pkg::RUN_W'(1);
            end else begin
                r_reps <= r_run;
                r_run  <= '0;
            end
        end else if (i_cmd.step) begin
            r_reps <= r_reps - rpd_pkg::RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
        end
    end

    // Position counters advance one encoded byte per repetition.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_plane    <= '0;
            r_row      <= '0;
            r_finished <= 1'b0;
        end else if (i_cmd.step) begin
            if (line_end) begin
                r_col <= '0;
                if (plane_wrap) begin
                    r_plane <= '0;
                    if (row_wrap) begin
                        r_row      <= '0;
                        r_finished <= 1'b1;
                    end else begin
                        r_row <= ROW_W'(row_nx);
                    end
                end else begin
                    r_plane <= PL_W'(plane_nx);
                end
            end else begin
                r_col <= COL_W'(col_nx);
            end
        end
    end

    // Output register: loaded by a repetition inside the image, emptied
    // when the downstream side takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && put) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && put) begin
            r_out_addr  <= pix_addr;
            r_out_value <= r_byte;
            r_out_last  <= last;
            r_out_done  <= done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_address = r_out_addr;
    assign o_pixel_value   = r_out_value;
    assign o_last_of_run   = r_out_last;
    assign o_image_done    = r_out_done;

endmodule
